// ===== sv/zfc_pkg.sv =====
package zfc_pkg;

   // Vertex space and derived widths
   localparam int MaxVertices = 64;
   localparam int IdxW        = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
   localparam int SetW        = 64;
   localparam int RowW        = 6;
   localparam int CountW      = 7;
   localparam logic [SetW-1:0] SpaceMask =
      (MaxVertices >= SetW) ? {SetW{1'b1}} : ((64'd1 << MaxVertices) - 64'd1);

   // Command queue depth between front and back
   localparam int QueueDepth = 2;
   localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QCntW      = $clog2(QueueDepth + 1);

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   // One classified command word
   typedef struct packed {
      req_kind_type      kind;
      logic [RowW-1:0]   row;
      logic [SetW-1:0]   data;
   } cmd_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_RUN,
      BACK_SUM
   } back_state_type;

   // Mask of the low n vertices, n saturating at the set width
   function automatic logic [SetW-1:0] low_mask(input logic [CountW-1:0] n);
      logic [SetW-1:0] m;
      if (n >= CountW'(SetW)) begin
         m = {SetW{1'b1}};
      end else begin
         m = (64'd1 << n) - 64'd1;
      end
      return m;
   endfunction

   // Population count: per byte, then sum of the bytes
   function automatic logic [CountW-1:0] pop_count(input logic [SetW-1:0] x);
      logic [3:0]        part [SetW/8];
      logic [CountW-1:0] sum;
      sum = '0;
      for (int b = 0; b < SetW / 8; b++) begin
         part[b] = '0;
         for (int k = 0; k < 8; k++) begin
            part[b] = part[b] + 4'(x[b*8+k]);
         end
      end
      for (int b = 0; b < SetW / 8; b++) begin
         sum = sum + CountW'(part[b]);
      end
      return sum;
   endfunction

endpackage

// ===== sv/zero_forcing_closure.sv =====
// Zero-forcing closure over up to 64 vertices held as adjacency rows.
// A query runs forcing rounds, one round a cycle over all rows, until a round
// turns no vertex blue; its result word is then registered for the output.
// The back end takes no new command while a query runs its rounds or waits to
// load its result word; a row write is taken in the idle state.
// Reset (synchronous, active high): rows read as empty, queue emptied, vertex_count 64.
module zero_forcing_closure (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_type,
   input  logic [zfc_pkg::RowW-1:0]    req_row_index,
   input  logic [zfc_pkg::SetW-1:0]    req_row_bits,
   input  logic [zfc_pkg::SetW-1:0]    req_seed_set,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [zfc_pkg::SetW-1:0]    rsp_closed_set,
   output logic [zfc_pkg::CountW-1:0]  rsp_blue_count,
   output logic                        rsp_all_blue,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [zfc_pkg::CountW-1:0]  csr_vertex_count
);

   logic             push_valid, push_ready;
   zfc_pkg::cmd_type push_cmd;
   logic             pop_valid, pop_ready;
   zfc_pkg::cmd_type pop_cmd;

   // Take a register word in any cycle
   assign csr_ready = 1'b1;

   zfc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_row_index (req_row_index),
      .req_row_bits  (req_row_bits),
      .req_seed_set  (req_seed_set),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_cmd      (push_cmd)
   );

   zfc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   zfc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_vertex_count (csr_vertex_count),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_cmd          (pop_cmd),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_closed_set   (rsp_closed_set),
      .rsp_blue_count   (rsp_blue_count),
      .rsp_all_blue     (rsp_all_blue)
   );

endmodule

// ===== sv/zfc_front.sv =====
module zfc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_type,
   input  logic [zfc_pkg::RowW-1:0]  req_row_index,
   input  logic [zfc_pkg::SetW-1:0]  req_row_bits,
   input  logic [zfc_pkg::SetW-1:0]  req_seed_set,
   output logic                      push_valid,
   input  logic                      push_ready,
   output zfc_pkg::cmd_type          push_cmd
);

   logic             hold_valid_ff, hold_valid_in;
   zfc_pkg::cmd_type hold_ff, hold_in;
   logic             accept;
   logic             keep;
   logic             in_range;

   // Classify: drop writes outside the vertex space, mask payload bits
   assign accept   = req_valid && req_ready;
   assign in_range = ({1'b0, req_row_index} < (zfc_pkg::RowW + 1)'(zfc_pkg::MaxVertices));
   assign keep     = (zfc_pkg::req_kind_type'(req_type) == zfc_pkg::REQ_QUERY) || in_range;

   always_comb begin
      hold_in.kind = zfc_pkg::req_kind_type'(req_type);
      hold_in.row  = req_row_index;
      if (zfc_pkg::req_kind_type'(req_type) == zfc_pkg::REQ_QUERY) begin
         hold_in.data = req_seed_set & zfc_pkg::SpaceMask;
      end else begin
         hold_in.data = req_row_bits & zfc_pkg::SpaceMask;
      end
   end

   // Hold one word until the queue takes it
   assign push_valid = hold_valid_ff;
   assign push_cmd   = hold_ff;
   assign req_ready  = !hold_valid_ff || push_ready;

   always_comb begin
      hold_valid_in = hold_valid_ff && !push_ready;
      if (accept && keep) begin
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && keep) begin
         hold_ff <= hold_in;
      end
   end

endmodule

// ===== sv/zfc_fifo.sv =====
module zfc_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  zfc_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output zfc_pkg::cmd_type pop_cmd
);

   zfc_pkg::cmd_type              slots_ff [zfc_pkg::QueueDepth];
   logic [zfc_pkg::QPtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [zfc_pkg::QPtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [zfc_pkg::QCntW-1:0]     count_ff, count_in;
   logic                          do_push, do_pop;

   assign push_ready = (count_ff != zfc_pkg::QCntW'(zfc_pkg::QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == zfc_pkg::QPtrW'(zfc_pkg::QueueDepth - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == zfc_pkg::QPtrW'(zfc_pkg::QueueDepth - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/zfc_back.sv =====
module zfc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   input  logic [zfc_pkg::CountW-1:0]  csr_vertex_count,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  zfc_pkg::cmd_type            pop_cmd,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [zfc_pkg::SetW-1:0]    rsp_closed_set,
   output logic [zfc_pkg::CountW-1:0]  rsp_blue_count,
   output logic                        rsp_all_blue
);

   localparam int NV = zfc_pkg::MaxVertices;

   zfc_pkg::back_state_type         state_ff, state_in;
   logic [zfc_pkg::SetW-1:0]        rows_ff [NV];
   logic [NV-1:0]                   row_valid_ff, row_valid_in;
   logic [zfc_pkg::SetW-1:0]        blue_ff, blue_in;
   logic [zfc_pkg::CountW-1:0]      vcount_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [zfc_pkg::SetW-1:0]        closed_ff;
   logic [zfc_pkg::CountW-1:0]      count_ff;
   logic                            all_blue_ff;

   logic [zfc_pkg::SetW-1:0]        lane_force [NV];
   logic [zfc_pkg::SetW-1:0]        forced;
   logic                            grown;
   logic                            take_cmd;
   logic                            write_row;
   logic                            load_out;
   logic [zfc_pkg::CountW-1:0]      used;
   logic [zfc_pkg::SetW-1:0]        full_mask;

   // One lane per vertex: a blue vertex with one white neighbour forces it
   for (genvar v = 0; v < NV; v++) begin : g_lane
      logic [zfc_pkg::SetW-1:0] row_eff;
      logic [zfc_pkg::SetW-1:0] white;
      logic                     single;
      assign row_eff = row_valid_ff[v] ? rows_ff[v] : '0;
      assign white   = row_eff & ~blue_ff;
      assign single  = (white != '0) && ((white & (white - 1'b1)) == '0);
      assign lane_force[v] = (blue_ff[v] && single) ? white : '0;
   end

   // Merge the forces of all lanes for one round
   always_comb begin
      forced = '0;
      for (int v = 0; v < NV; v++) begin
         forced = forced | lane_force[v];
      end
   end

   assign grown = ((forced & ~blue_ff) != '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         zfc_pkg::BACK_IDLE: begin
            if (pop_valid && pop_cmd.kind == zfc_pkg::REQ_QUERY) begin
               state_in = zfc_pkg::BACK_RUN;
            end
         end
         zfc_pkg::BACK_RUN: begin
            if (!grown) begin
               state_in = zfc_pkg::BACK_SUM;
            end
         end
         zfc_pkg::BACK_SUM: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = zfc_pkg::BACK_IDLE;
            end
         end
         default: state_in = zfc_pkg::BACK_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      pop_ready = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         zfc_pkg::BACK_IDLE: pop_ready = 1'b1;
         zfc_pkg::BACK_RUN:  pop_ready = 1'b0;
         zfc_pkg::BACK_SUM:  load_out  = !rsp_valid_ff || rsp_ready;
         default:            pop_ready = 1'b0;
      endcase
   end

   assign take_cmd  = pop_valid && pop_ready;
   assign write_row = take_cmd && (pop_cmd.kind == zfc_pkg::REQ_WRITE);

   // Blue set: load the seed, then grow one round a cycle
   always_comb begin
      blue_in = blue_ff;
      if (take_cmd && pop_cmd.kind == zfc_pkg::REQ_QUERY) begin
         blue_in = pop_cmd.data;
      end else if (state_ff == zfc_pkg::BACK_RUN) begin
         blue_in = blue_ff | forced;
      end
   end

   always_comb begin
      row_valid_in = row_valid_ff;
      if (write_row) begin
         row_valid_in[pop_cmd.row[zfc_pkg::IdxW-1:0]] = 1'b1;
      end
   end

   // Result word: count and full-set test off the final blue set
   assign used      = (vcount_ff > zfc_pkg::CountW'(NV)) ? zfc_pkg::CountW'(NV) : vcount_ff;
   assign full_mask = zfc_pkg::low_mask(used);

   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= zfc_pkg::BACK_IDLE;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         vcount_ff    <= zfc_pkg::CountW'(64);
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            vcount_ff <= csr_vertex_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      blue_ff <= blue_in;
      if (write_row) begin
         rows_ff[pop_cmd.row[zfc_pkg::IdxW-1:0]] <= pop_cmd.data;
      end
      if (load_out) begin
         closed_ff   <= blue_ff;
         count_ff    <= zfc_pkg::pop_count(blue_ff);
         all_blue_ff <= (blue_ff == full_mask);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_closed_set = closed_ff;
   assign rsp_blue_count = count_ff;
   assign rsp_all_blue   = all_blue_ff;

endmodule

// ===== sv/zfc_checker.sv =====
module zfc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [zfc_pkg::SetW-1:0]    rsp_closed_set,
   input logic [zfc_pkg::CountW-1:0]  rsp_blue_count,
   input logic                        rsp_all_blue
);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_closed_set))
      else $error("result word changed while stalled");

   // Count matches the set
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_blue_count == zfc_pkg::CountW'($countones(rsp_closed_set)))
      else $error("blue_count differs from closed_set population");

   // A full set is always a run of low vertices
   a_full_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_all_blue |-> (rsp_closed_set & (rsp_closed_set + 1'b1)) == '0)
      else $error("all_blue set on a set that is not a low mask");

   // Drop results on reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind zero_forcing_closure zfc_checker u_zfc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_closed_set (rsp_closed_set),
   .rsp_blue_count (rsp_blue_count),
   .rsp_all_blue   (rsp_all_blue)
);

// ===== tb/zero_forcing_closure_tb.sv =====
module zero_forcing_closure_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DrainCycles = 80;

   typedef struct {
      logic [zfc_pkg::SetW-1:0]   closed;
      logic [zfc_pkg::CountW-1:0] count;
      logic                       all_blue;
   } closure_type;

   typedef enum int {
      GRAPH_PATH,
      GRAPH_CYCLE,
      GRAPH_TREE,
      GRAPH_SPARSE,
      GRAPH_DIRECTED
   } graph_kind_type;

   typedef enum int {
      RECV_OPEN,
      RECV_LIGHT,
      RECV_SPARSE,
      RECV_HEAVY
   } recv_mode_type;

   // Shadow of the adjacency rows and vertex_count; predicts one closure per query word
   class closure_tracker;
      logic [zfc_pkg::SetW-1:0]   rows [zfc_pkg::MaxVertices];
      logic [zfc_pkg::CountW-1:0] vertex_count;
      closure_type                pending_closures [$];
      int                         errors;

      function new();
         foreach (rows[i]) rows[i] = '0;
         vertex_count = zfc_pkg::CountW'(64);
         errors = 0;
      endfunction

      static function logic [zfc_pkg::SetW-1:0] first_n(int n);
         if (n >= zfc_pkg::SetW) return '1;
         return (64'd1 << n) - 64'd1;
      endfunction

      // Apply the color-change rule until no vertex turns blue
      function logic [zfc_pkg::SetW-1:0] force_to_fixed_point(logic [zfc_pkg::SetW-1:0] blue);
         logic [zfc_pkg::SetW-1:0] prior;
         logic [zfc_pkg::SetW-1:0] white;
         do begin
            prior = blue;
            for (int v = 0; v < zfc_pkg::MaxVertices; v++) begin
               if (prior[v]) begin
                  white = rows[v] & ~blue;
                  if (white != '0 && (white & (white - 64'd1)) == '0) blue = blue | white;
               end
            end
         end while (blue != prior);
         return blue;
      endfunction

      function void set_vertex_count(logic [zfc_pkg::CountW-1:0] value);
         vertex_count = value;
      endfunction

      // Note an accepted input word: store a row or queue the predicted closure
      function void note_word(zfc_pkg::req_kind_type kind, logic [zfc_pkg::RowW-1:0] row,
                              logic [zfc_pkg::SetW-1:0] bits, logic [zfc_pkg::SetW-1:0] seed);
         closure_type want;
         int          used;
         if (kind == zfc_pkg::REQ_WRITE) begin
            if (row < zfc_pkg::MaxVertices) rows[row] = bits & zfc_pkg::SpaceMask;
            return;
         end
         used = (vertex_count > zfc_pkg::MaxVertices) ? zfc_pkg::MaxVertices : vertex_count;
         want.closed   = force_to_fixed_point(seed & zfc_pkg::SpaceMask);
         want.count    = zfc_pkg::CountW'($countones(want.closed));
         want.all_blue = (want.closed == first_n(used));
         pending_closures.insert(pending_closures.size(), want);
      endfunction

      // Compare one result word with the oldest predicted closure
      function void check_word(logic [zfc_pkg::SetW-1:0] closed,
                               logic [zfc_pkg::CountW-1:0] count, logic all_blue);
         closure_type want;
         if (pending_closures.size() == 0) begin
            $display("%0t: result with none expected, closed_set %h", $time, closed);
            errors++;
            return;
         end
         want = pending_closures.pop_front();
         if (closed !== want.closed) begin
            $display("%0t: closed_set expected %h actual %h", $time, want.closed, closed);
            errors++;
         end
         if (count !== want.count) begin
            $display("%0t: blue_count expected %0d actual %0d", $time, want.count, count);
            errors++;
         end
         if (all_blue !== want.all_blue) begin
            $display("%0t: all_blue expected %b actual %b", $time, want.all_blue, all_blue);
            errors++;
         end
      endfunction

      function int failures();
         if (pending_closures.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_closures.size());
         end
         return errors + pending_closures.size();
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic                         req_type;
   logic [zfc_pkg::RowW-1:0]     req_row_index;
   logic [zfc_pkg::SetW-1:0]     req_row_bits;
   logic [zfc_pkg::SetW-1:0]     req_seed_set;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [zfc_pkg::SetW-1:0]     rsp_closed_set;
   logic [zfc_pkg::CountW-1:0]   rsp_blue_count;
   logic                         rsp_all_blue;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [zfc_pkg::CountW-1:0]   csr_vertex_count;

   closure_tracker               tracker;
   int                           burst_left;
   int                           hold_request;
   logic [zfc_pkg::SetW-1:0]     graph [zfc_pkg::MaxVertices];
   int                           graph_perm [zfc_pkg::MaxVertices];

   zero_forcing_closure i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_row_index    (req_row_index),
      .req_row_bits     (req_row_bits),
      .req_seed_set     (req_seed_set),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_closed_set   (rsp_closed_set),
      .rsp_blue_count   (rsp_blue_count),
      .rsp_all_blue     (rsp_all_blue),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_vertex_count (csr_vertex_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic logic [zfc_pkg::SetW-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Offer one word in bursts, idling a random gap between bursts
   task automatic send_word(zfc_pkg::req_kind_type kind, logic [zfc_pkg::RowW-1:0] row,
                            logic [zfc_pkg::SetW-1:0] bits, logic [zfc_pkg::SetW-1:0] seed);
      int gap;
      @(negedge clock);
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12)
                                                 : $urandom_range(30, 120);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_row_index <= row;
      req_row_bits  <= bits;
      req_seed_set  <= seed;
      burst_left--;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_word(kind, row, bits, seed);
   endtask

   task automatic write_row(int row, logic [zfc_pkg::SetW-1:0] bits);
      send_word(zfc_pkg::REQ_WRITE, zfc_pkg::RowW'(row), bits, rand_word());
   endtask

   task automatic query(logic [zfc_pkg::SetW-1:0] seed);
      send_word(zfc_pkg::REQ_QUERY, zfc_pkg::RowW'($urandom), rand_word(), seed);
   endtask

   // Drop valid, drain every expected word, then let a trailing write finish
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (tracker.pending_closures.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic set_vertex_count(int value);
      settle();
      csr_valid        <= 1'b1;
      csr_vertex_count <= zfc_pkg::CountW'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.set_vertex_count(zfc_pkg::CountW'(value));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void link(int a, int b);
      graph[a][b] = 1'b1;
      graph[b][a] = 1'b1;
   endfunction

   // Build a random graph on the first n vertices and write all rows
   task automatic load_graph(int n);
      graph_kind_type kind;
      int             j;
      int             swap;
      kind = graph_kind_type'($urandom_range(0, 4));
      foreach (graph_perm[i]) graph_perm[i] = i;
      for (int i = n - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         swap = graph_perm[i];
         graph_perm[i] = graph_perm[j];
         graph_perm[j] = swap;
      end
      foreach (graph[i]) graph[i] = '0;
      case (kind)
         GRAPH_PATH, GRAPH_CYCLE: begin
            for (int i = 0; i < n - 1; i++) link(graph_perm[i], graph_perm[i + 1]);
            if (kind == GRAPH_CYCLE && n > 2) link(graph_perm[n - 1], graph_perm[0]);
         end
         GRAPH_TREE: begin
            for (int i = 1; i < n; i++) link(graph_perm[$urandom_range(0, i - 1)], graph_perm[i]);
         end
         GRAPH_SPARSE: begin
            for (int a = 0; a < n; a++) begin
               for (int b = a + 1; b < n; b++) begin
                  if ($urandom_range(0, n - 1) < 2) link(a, b);
               end
            end
         end
         default: begin
            // one-way rows with the odd self loop
            for (int v = 0; v < n; v++) begin
               graph[v] = rand_word() & rand_word() & rand_word() & closure_tracker::first_n(n);
               if ($urandom_range(0, 3) == 0) graph[v][v] = 1'b1;
            end
         end
      endcase
      // noise in rows of unused vertices
      for (int v = n; v < zfc_pkg::MaxVertices; v++) begin
         if ($urandom_range(0, 7) == 0) graph[v] = rand_word();
      end
      for (int v = 0; v < zfc_pkg::MaxVertices; v++) write_row(v, graph[v]);
   endtask

   function automatic logic [zfc_pkg::SetW-1:0] pick_seed(int n, int used);
      logic [zfc_pkg::SetW-1:0] seed;
      int                       pick;
      int                       bit_at;
      seed = '0;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         repeat ($urandom_range(1, 3)) begin
            bit_at = $urandom_range(0, n - 1);
            seed[bit_at] = 1'b1;
         end
      end else if (pick < 55) begin
         seed = rand_word() & rand_word() & closure_tracker::first_n(n);
      end else if (pick < 63) begin
         seed = closure_tracker::first_n(used);
      end else if (pick < 75) begin
         seed[graph_perm[0]] = 1'b1;
      end else if (pick < 85) begin
         // a vertex of the graph plus one beyond the used range, if there is one
         bit_at = $urandom_range(0, n - 1);
         seed[bit_at] = 1'b1;
         bit_at = (used < zfc_pkg::MaxVertices) ? $urandom_range(used, zfc_pkg::MaxVertices - 1)
                                                : $urandom_range(0, zfc_pkg::MaxVertices - 1);
         seed[bit_at] = 1'b1;
      end else if (pick < 96) begin
         seed = rand_word();
      end
      return seed;
   endfunction

   // Receiver: stall pattern is picked anew at random over the run; long hold-off on request
   initial begin
      recv_mode_type mode;
      int            hold_left;
      int            cycles;
      mode      = RECV_OPEN;
      hold_left = 0;
      cycles    = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         cycles++;
         if (cycles % 250 == 0) mode = recv_mode_type'($urandom_range(0, 3));
         if (hold_left == 0 && hold_request != 0) begin
            hold_left = 400;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               RECV_OPEN:   rsp_ready <= 1'b1;
               RECV_LIGHT:  rsp_ready <= ($urandom_range(0, 9) >= 3);
               RECV_SPARSE: rsp_ready <= (cycles % 4 == 0);
               default:     rsp_ready <= ($urandom_range(0, 9) < 2);
            endcase
         end
      end
   end

   // Check each accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_word(rsp_closed_set, rsp_blue_count, rsp_all_blue);
      end
   end

   initial begin
      int plan [6];
      int used;
      int n;
      tracker          = new();
      burst_left       = 0;
      hold_request     = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = zfc_pkg::REQ_WRITE;
      req_row_index    = '0;
      req_row_bits     = '0;
      req_seed_set     = '0;
      csr_valid        = 1'b0;
      csr_vertex_count = '0;
      foreach (graph_perm[i]) graph_perm[i] = i;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty graph, dense and one-way rows, self loop, count extremes
      query('0);
      query('1);
      write_row(0, ~64'h1);
      query(64'h1);
      write_row(63, 64'h1 << 62);
      query(64'h1 << 63);
      write_row(5, (64'h1 << 5) | (64'h1 << 6));
      query(64'h1 << 5);
      write_row(0, '0);
      write_row(63, '1);
      query(~64'h1);
      set_vertex_count(0);
      query('0);
      query(64'h1 << 40);
      set_vertex_count(127);
      query('1);
      set_vertex_count(1);
      query(64'h1);
      query(64'h3);

      // Random: graphs of random shape under several vertex counts
      plan = '{64, 1, $urandom_range(2, 62), 0, 127, 63};
      for (int p = 0; p < 6; p++) begin
         set_vertex_count(plan[p]);
         used = (plan[p] > zfc_pkg::MaxVertices) ? zfc_pkg::MaxVertices : plan[p];
         n = (used >= 2) ? used : $urandom_range(2, zfc_pkg::MaxVertices);
         for (int g = 0; g < 2; g++) begin
            load_graph(n);
            if (p == 2 && g == 0) hold_request = 1;
            for (int q = 0; q < 45; q++) begin
               if ($urandom_range(0, 19) == 0) begin
                  write_row($urandom_range(0, zfc_pkg::MaxVertices - 1), rand_word());
               end else begin
                  query(pick_seed(n, used));
               end
            end
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (tracker.failures() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
